// ===== src/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg: shared types for typed symbol capture
// Command passed from the classifier to the result sequencer, and the codes
// used on both sides of the command queue.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int CNT_W  = 5;
   localparam int CHAR_W = 7;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_START,
      OP_APPEND,
      OP_COMMIT
   } op_type;

   typedef enum logic [2:0] {
      KIND_KEY        = 3'd0,
      KIND_START      = 3'd1,
      KIND_BS_PRESS   = 3'd2,
      KIND_BS_RELEASE = 3'd3,
      KIND_END        = 3'd4,
      KIND_CHAR       = 3'd5,
      KIND_DONE       = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_BS_PRESS,
      BK_BS_RELEASE,
      BK_END,
      BK_CHAR,
      BK_DONE,
      BK_KEY
   } bk_state_type;

   // count carries the store index for OP_APPEND and the length for OP_COMMIT
   typedef struct packed {
      op_type            op;
      logic [7:0]        code;
      logic [7:0]        flags;
      logic [CNT_W-1:0]  count;
      logic [CHAR_W-1:0] sym;
   } cmd_type;

endpackage

// ===== src/tsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_front: key event classifier
// Tracks the capture state and character count, decodes each key event and
// issues one command per transaction to the command queue.
// ----------------------------------------------------------------------------
module tsc_front #(
   parameter int MAX_SYMBOL_LEN = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              req_push,
   input  logic [7:0]        req_key_code,
   input  logic [7:0]        req_key_flags,
   input  logic              req_now_pressed,
   input  logic              req_prev_pressed,
   input  logic              req_injected,
   input  logic              q_full,
   output logic              q_push,
   output tsc_pkg::cmd_type  q_cmd
);

   localparam logic [7:0] CODE_BACKSPACE = 8'h2A;
   localparam logic [7:0] CODE_SPACE     = 8'h2C;
   localparam logic [7:0] CODE_A         = 8'h04;
   localparam logic [7:0] CODE_Z         = 8'h1D;
   localparam logic [7:0] CODE_1         = 8'h1E;
   localparam logic [7:0] CODE_0         = 8'h27;
   localparam logic [tsc_pkg::CNT_W-1:0] MAX_CNT = tsc_pkg::CNT_W'(MAX_SYMBOL_LEN);

   function automatic logic [tsc_pkg::CHAR_W-1:0] key_char(
      input logic [7:0] code,
      input logic [7:0] flags
   );
      logic [7:0] ch;
      ch = 8'd0;
      if (flags == 8'd0) begin
         if (code >= CODE_A && code <= CODE_Z) begin
            ch = 8'd97 + (code - CODE_A);
         end else if (code >= CODE_1 && code < CODE_0) begin
            ch = 8'd49 + (code - CODE_1);
         end else if (code == CODE_0) begin
            ch = 8'd48;
         end
      end
      return ch[tsc_pkg::CHAR_W-1:0];
   endfunction

   logic [15:0]               trigger_ff;
   logic                      capturing_ff, capturing_in;
   logic [tsc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      accept, on, off, is_trig, is_bs, is_sp;
   logic [tsc_pkg::CHAR_W-1:0] ch;

   assign accept  = req_push && !q_full;
   assign q_push  = accept;
   assign on      = req_now_pressed && !req_prev_pressed;
   assign off     = !req_now_pressed && req_prev_pressed;
   assign is_trig = {req_key_flags, req_key_code} == trigger_ff;
   assign is_bs   = (req_key_code == CODE_BACKSPACE) && (req_key_flags == 8'd0);
   assign is_sp   = (req_key_code == CODE_SPACE) && (req_key_flags == 8'd0);
   assign ch      = key_char(req_key_code, req_key_flags);

   always_comb begin
      capturing_in = capturing_ff;
      count_in     = count_ff;
      q_cmd.op     = tsc_pkg::OP_PASS;
      q_cmd.code   = req_key_code;
      q_cmd.flags  = req_key_flags;
      q_cmd.count  = count_ff;
      q_cmd.sym    = ch;
      priority if (!capturing_ff) begin
         if (is_trig) begin
            q_cmd.code  = 8'd0;
            q_cmd.flags = 8'd0;
            if (on) begin
               capturing_in = 1'b1;
               q_cmd.op     = tsc_pkg::OP_START;
            end
         end
      end else if (req_injected) begin
         q_cmd.op = tsc_pkg::OP_PASS;
      end else if (is_trig || (is_bs && count_ff == '0)) begin
         q_cmd.code  = 8'd0;
         q_cmd.flags = 8'd0;
      end else if (off && is_sp) begin
         q_cmd.op     = tsc_pkg::OP_COMMIT;
         q_cmd.code   = 8'd0;
         q_cmd.flags  = 8'd0;
         capturing_in = 1'b0;
         count_in     = '0;
      end else if (on) begin
         if (is_bs) begin
            count_in = count_ff - tsc_pkg::CNT_W'(1);
         end else if (ch != '0 && count_ff < MAX_CNT) begin
            q_cmd.op = tsc_pkg::OP_APPEND;
            count_in = count_ff + tsc_pkg::CNT_W'(1);
         end
      end else begin
         q_cmd.op = tsc_pkg::OP_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff   <= 16'hFFFF;
         capturing_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            trigger_ff <= csr_wdata;
         end
         if (accept) begin
            capturing_ff <= capturing_in;
            count_ff     <= count_in;
         end
      end
   end

endmodule

// ===== src/tsc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_queue: command queue
// Two-entry FIFO between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module tsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsc_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output tsc_pkg::cmd_type  pop_cmd,
   output logic              empty
);

   tsc_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff;

   assign full    = fill_ff == 2'd2;
   assign empty   = fill_ff == 2'd0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

// ===== src/tsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_back: result sequencer
// Holds the character store, executes one command at a time and emits its
// results one per cycle while the receiver pops, through a registered output.
// ----------------------------------------------------------------------------
module tsc_back #(
   parameter int MAX_SYMBOL_LEN = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  tsc_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_out_key_code,
   output logic [7:0]                  rsp_out_key_flags,
   output logic [tsc_pkg::CHAR_W-1:0]  rsp_symbol_char,
   output logic                        rsp_last
);

   localparam int IDX_W = (MAX_SYMBOL_LEN > 1) ? $clog2(MAX_SYMBOL_LEN) : 1;

   tsc_pkg::bk_state_type      state_ff, state_in;
   tsc_pkg::cmd_type           cmd_ff, cmd_in;
   logic [tsc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [tsc_pkg::CHAR_W-1:0] store_ff [MAX_SYMBOL_LEN];

   logic                       load, emit, last;
   tsc_pkg::kind_type          kind;
   logic [tsc_pkg::CHAR_W-1:0] sym;
   logic [7:0]                 code, flags;

   logic                       valid_ff;
   tsc_pkg::kind_type          kind_ff;
   logic [7:0]                 code_ff, flags_ff;
   logic [tsc_pkg::CHAR_W-1:0] sym_ff;
   logic                       last_ff;

   assign load = !valid_ff || rsp_pop;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      kind     = tsc_pkg::KIND_KEY;
      sym      = '0;
      code     = 8'd0;
      flags    = 8'd0;
      last     = 1'b0;
      unique case (state_ff)
         tsc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               cnt_in = '0;
               unique case (q_cmd.op)
                  tsc_pkg::OP_START:  state_in = tsc_pkg::BK_START;
                  tsc_pkg::OP_COMMIT: state_in = tsc_pkg::BK_BS_PRESS;
                  default:            state_in = tsc_pkg::BK_KEY;
               endcase
            end
         end
         tsc_pkg::BK_START: begin
            if (load) begin
               emit     = 1'b1;
               kind     = tsc_pkg::KIND_START;
               state_in = tsc_pkg::BK_KEY;
            end
         end
         tsc_pkg::BK_BS_PRESS: begin
            if (load) begin
               emit     = 1'b1;
               kind     = tsc_pkg::KIND_BS_PRESS;
               state_in = tsc_pkg::BK_BS_RELEASE;
            end
         end
         tsc_pkg::BK_BS_RELEASE: begin
            if (load) begin
               emit = 1'b1;
               kind = tsc_pkg::KIND_BS_RELEASE;
               if (cnt_ff == cmd_ff.count) begin
                  cnt_in   = '0;
                  state_in = tsc_pkg::BK_END;
               end else begin
                  cnt_in   = cnt_ff + tsc_pkg::CNT_W'(1);
                  state_in = tsc_pkg::BK_BS_PRESS;
               end
            end
         end
         tsc_pkg::BK_END: begin
            if (load) begin
               emit     = 1'b1;
               kind     = tsc_pkg::KIND_END;
               state_in = (cmd_ff.count == '0) ? tsc_pkg::BK_DONE : tsc_pkg::BK_CHAR;
            end
         end
         tsc_pkg::BK_CHAR: begin
            if (load) begin
               emit = 1'b1;
               kind = tsc_pkg::KIND_CHAR;
               sym  = store_ff[cnt_ff[IDX_W-1:0]];
               if (cnt_ff == cmd_ff.count - tsc_pkg::CNT_W'(1)) begin
                  state_in = tsc_pkg::BK_DONE;
               end else begin
                  cnt_in = cnt_ff + tsc_pkg::CNT_W'(1);
               end
            end
         end
         tsc_pkg::BK_DONE: begin
            if (load) begin
               emit     = 1'b1;
               kind     = tsc_pkg::KIND_DONE;
               state_in = tsc_pkg::BK_KEY;
            end
         end
         tsc_pkg::BK_KEY: begin
            if (load) begin
               emit     = 1'b1;
               kind     = tsc_pkg::KIND_KEY;
               code     = cmd_ff.code;
               flags    = cmd_ff.flags;
               last     = 1'b1;
               state_in = tsc_pkg::BK_IDLE;
            end
         end
         default: state_in = tsc_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_cmd.op == tsc_pkg::OP_APPEND) begin
         store_ff[q_cmd.count[IDX_W-1:0]] <= q_cmd.sym;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
      if (emit) begin
         kind_ff  <= kind;
         code_ff  <= code;
         flags_ff <= flags;
         sym_ff   <= sym;
         last_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsc_pkg::BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_key_code  = code_ff;
   assign rsp_out_key_flags = flags_ff;
   assign rsp_symbol_char   = sym_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== src/typed_symbol_capture_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_symbol_capture_core: symbol capture from a stream of key events
// Usage:
//   Input queue: drive the key event and req_push; the transaction is taken
//   when req_push is high and req_full is low.
//   Result queue: while rsp_empty is low the oldest result is on the rsp_
//   ports; rsp_pop takes it. rsp_last marks the final result of an event.
//   CSR: csr_we writes the trigger key (flags in bits 15..8, code in 7..0);
//   write it only while the block is idle (the block does not enforce this).
//   Each event gives one or more results, one per cycle while the receiver
//   keeps popping. The first result of an event passes through the command
//   queue, the sequencer state and the output register. A commit of n
//   characters emits 3n+5 results; other events give one or two. The result
//   sequencer is the limit: it handles one event at a time.
//   A two-entry command queue lets up to two events be accepted while the
//   sequencer is busy; req_full rises when it fills.
//   When the receiver stalls, the held result stays on the ports and the
//   sequencer waits. Reset clears capture state, the character count and queues
//   and sets the trigger key to 16'hFFFF; the character store is not cleared.
// ----------------------------------------------------------------------------
module typed_symbol_capture_core #(
   parameter int MAX_SYMBOL_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_key_code,
   input  logic [7:0]  req_key_flags,
   input  logic        req_now_pressed,
   input  logic        req_prev_pressed,
   input  logic        req_injected,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_key_code,
   output logic [7:0]  rsp_out_key_flags,
   output logic [6:0]  rsp_symbol_char,
   output logic        rsp_last
);

   tsc_pkg::cmd_type push_cmd, pop_cmd;
   logic             push, pop, q_full, q_empty;

   assign req_full = q_full;

   tsc_front #(.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_key_code     (req_key_code),
      .req_key_flags    (req_key_flags),
      .req_now_pressed  (req_now_pressed),
      .req_prev_pressed (req_prev_pressed),
      .req_injected     (req_injected),
      .q_full           (q_full),
      .q_push           (push),
      .q_cmd            (push_cmd)
   );

   tsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   tsc_back #(.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (pop_cmd),
      .q_pop             (pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_out_key_code  (rsp_out_key_code),
      .rsp_out_key_flags (rsp_out_key_flags),
      .rsp_symbol_char   (rsp_symbol_char),
      .rsp_last          (rsp_last)
   );

endmodule
